FILE: rtl/core/fat12_cluster_chain_walker_top_assert.svh
// assertion macros for the fat12 cluster chain walker checker
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define FCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcw assertion failed");

// next-cycle implication
`define FCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcw assertion failed");

`endif

FILE: rtl/core/fcw_pkg.sv
// shared constants for the fat12 cluster chain walker
package fcw_pkg;

  localparam int unsigned FAT_BYTES_DEF     = 8192;
  localparam int unsigned SEGMENT_BYTES_DEF = 65536;
  localparam int unsigned MAX_CLUSTERS_DEF  = 64;

  localparam int unsigned LK_W       = 13;
  localparam int unsigned CLU_SIZE_W = 21;

  localparam logic [11:0] END_OF_CHAIN = 12'hff8;
  localparam logic [15:0] END_OF_FILE  = 16'hffff;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_WALK = 1'b1;

  localparam logic [1:0] REG_SPC = 2'd0;
  localparam logic [1:0] REG_SB  = 2'd1;
  localparam logic [1:0] REG_DS  = 2'd2;

  localparam logic [7:0]  SPC_RST = 8'd1;
  localparam logic [12:0] SB_RST  = 13'd512;
  localparam logic [15:0] DS_RST  = 16'd33;

endpackage

FILE: rtl/core/fat12_cluster_chain_walker_top.sv
// fat12 cluster chain walker: fat store, chain sequencer and config registers
// load transaction: written in the accept cycle, no result, ready again next cycle
// walk transaction: a start step computes the cluster size, then each cluster takes a sector step,
//   two fat byte reads through the single read port and an emit step (held while the output stalls), up to 64
// end-of-chain start: one result, emitted straight after the start step; not ready while a walk runs
// reset: config to 1 / 512 / 33, control cleared, fat contents undefined, no clear pass
module fat12_cluster_chain_walker_top #(
  parameter int unsigned FAT_BYTES             = fcw_pkg::FAT_BYTES_DEF,
  parameter int unsigned SEGMENT_BYTES         = fcw_pkg::SEGMENT_BYTES_DEF,
  parameter int unsigned MAX_CLUSTERS_PER_WALK = fcw_pkg::MAX_CLUSTERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [12:0] fat_index_i,
  input  logic [7:0]  fat_byte_i,
  input  logic [11:0] start_cluster_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_read_o,
  output logic [15:0] sector_o,
  output logic [15:0] dest_offset_o,
  output logic [15:0] next_cluster_o,
  output logic        last_o
);

  localparam int unsigned AddrW = $clog2(FAT_BYTES);
  localparam int unsigned CntW  = $clog2(MAX_CLUSTERS_PER_WALK + 1);
  localparam int unsigned SegW  = $clog2(SEGMENT_BYTES + 1);
  localparam int unsigned CluW  = fcw_pkg::CLU_SIZE_W;
  localparam int unsigned AccW  = ((SegW > CluW + 1) ? SegW : CluW + 1) + 1;
  localparam int unsigned LkW   = fcw_pkg::LK_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SECT  = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_RD2   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [7:0]  spc_q;
  logic [12:0] sb_q;
  logic [15:0] ds_q;
  logic        cfg_we;

  logic [2:0]      state_q, state_d;
  logic [11:0]     clu_q, clu_d;
  logic [CluW-1:0] csize_q, csize_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [15:0]     sector_q, sector_d;
  logic [7:0]      lo_q, lo_d;
  logic [11:0]     nclu_q, nclu_d;
  logic            eoc_q, eoc_d;
  logic            seg_done_q, seg_done_d;
  logic            rd_oor_q;

  logic        ovalid_q, ovalid_d;
  logic        oread_q, oread_d;
  logic [15:0] osector_q, osector_d;
  logic [15:0] ooffset_q, ooffset_d;
  logic [15:0] onext_q, onext_d;
  logic        olast_q, olast_d;

  logic             in_fire;
  logic             mem_we;
  logic [7:0]       mem_rdata;
  logic [7:0]       rbyte;
  logic [LkW-1:0]   lk_base;
  logic [LkW-1:0]   lk_lo;
  logic [LkW-1:0]   lk_hi;
  logic [LkW-1:0]   lk_addr;
  logic [15:0]      mul_a;
  logic [23:0]      mul_p;
  logic [AccW-1:0]  acc_far;
  logic             emit_ok;
  logic             walk_done;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q <= fcw_pkg::SPC_RST;
      sb_q  <= fcw_pkg::SB_RST;
      ds_q  <= fcw_pkg::DS_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        fcw_pkg::REG_SPC: spc_q <= pwdata[7:0];
        fcw_pkg::REG_SB:  sb_q  <= pwdata[12:0];
        fcw_pkg::REG_DS:  ds_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fcw_pkg::REG_SPC: prdata = {24'd0, spc_q};
      fcw_pkg::REG_SB:  prdata = {19'd0, sb_q};
      fcw_pkg::REG_DS:  prdata = {16'd0, ds_q};
      default:          prdata = 32'd0;
    endcase
  end

  // fat store
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign mem_we     = in_fire & (action_i == fcw_pkg::ACT_LOAD) &
                      (32'(fat_index_i) < FAT_BYTES);

  assign lk_base = {2'b00, clu_q[11:1]} + {1'b0, clu_q[11:1], 1'b0};
  assign lk_lo   = lk_base + {{(LkW-1){1'b0}}, clu_q[0]};
  assign lk_hi   = lk_lo + {{(LkW-1){1'b0}}, 1'b1};
  assign lk_addr = (state_q == S_SECT) ? lk_lo : lk_hi;

  fcw_fat_mem #(
    .Depth(FAT_BYTES)
  ) u_fat_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(fat_index_i)),
    .wdata_i (fat_byte_i),
    .raddr_i (AddrW'(lk_addr)),
    .rdata_o (mem_rdata)
  );

  // lookups beyond the store read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_oor_q <= 1'b0;
    end else begin
      rd_oor_q <= (32'(lk_addr) >= FAT_BYTES);
    end
  end

  assign rbyte = rd_oor_q ? 8'd0 : mem_rdata;

  // shared multiplier: cluster size at start, sector offset per cluster
  assign mul_a = (state_q == S_START) ? {3'd0, sb_q} : ({4'd0, clu_q} - 16'd2);
  assign mul_p = mul_a * spc_q;

  assign acc_far   = acc_q + {csize_q, 1'b0};
  assign emit_ok   = ~ovalid_q | out_ready_i;
  assign walk_done = (nclu_q >= fcw_pkg::END_OF_CHAIN) | seg_done_q;

  always_comb begin
    state_d    = state_q;
    clu_d      = clu_q;
    csize_d    = csize_q;
    acc_d      = acc_q;
    idx_d      = idx_q;
    sector_d   = sector_q;
    lo_d       = lo_q;
    nclu_d     = nclu_q;
    eoc_d      = eoc_q;
    seg_done_d = seg_done_q;
    ovalid_d   = ovalid_q & ~out_ready_i;
    oread_d    = oread_q;
    osector_d  = osector_q;
    ooffset_d  = ooffset_q;
    onext_d    = onext_q;
    olast_d    = olast_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire && action_i == fcw_pkg::ACT_WALK) begin
          clu_d   = start_cluster_i;
          acc_d   = '0;
          idx_d   = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        csize_d = mul_p[CluW-1:0];
        eoc_d   = (clu_q >= fcw_pkg::END_OF_CHAIN);
        state_d = (clu_q >= fcw_pkg::END_OF_CHAIN) ? S_EMIT : S_SECT;
      end
      S_SECT: begin
        sector_d = ds_q + mul_p[15:0];
        state_d  = S_RD1;
      end
      S_RD1: begin
        lo_d    = rbyte;
        state_d = S_RD2;
      end
      S_RD2: begin
        nclu_d     = clu_q[0] ? {rbyte, lo_q[7:4]} : {rbyte[3:0], lo_q};
        seg_done_d = (idx_q == CntW'(MAX_CLUSTERS_PER_WALK - 1)) ||
                     ((csize_q != '0) && (acc_far > AccW'(SEGMENT_BYTES)));
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          ovalid_d = 1'b1;
          if (eoc_q) begin
            oread_d   = 1'b0;
            osector_d = 16'd0;
            ooffset_d = 16'd0;
            onext_d   = fcw_pkg::END_OF_FILE;
            olast_d   = 1'b1;
            state_d   = S_IDLE;
          end else begin
            oread_d   = 1'b1;
            osector_d = sector_q;
            ooffset_d = acc_q[15:0];
            olast_d   = walk_done;
            if (!walk_done) begin
              onext_d = 16'd0;
            end else if (nclu_q >= fcw_pkg::END_OF_CHAIN) begin
              onext_d = fcw_pkg::END_OF_FILE;
            end else begin
              onext_d = {4'd0, nclu_q};
            end
            if (walk_done) begin
              state_d = S_IDLE;
            end else begin
              clu_d   = nclu_q;
              idx_d   = idx_q + CntW'(1);
              acc_d   = acc_q + AccW'(csize_q);
              state_d = S_SECT;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      eoc_q    <= 1'b0;
      idx_q    <= '0;
      acc_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      eoc_q    <= eoc_d;
      idx_q    <= idx_d;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clu_q      <= clu_d;
    csize_q    <= csize_d;
    sector_q   <= sector_d;
    lo_q       <= lo_d;
    nclu_q     <= nclu_d;
    seg_done_q <= seg_done_d;
    oread_q    <= oread_d;
    osector_q  <= osector_d;
    ooffset_q  <= ooffset_d;
    onext_q    <= onext_d;
    olast_q    <= olast_d;
  end

  assign out_valid_o    = ovalid_q;
  assign is_read_o      = oread_q;
  assign sector_o       = osector_q;
  assign dest_offset_o  = ooffset_q;
  assign next_cluster_o = onext_q;
  assign last_o         = olast_q;

endmodule

FILE: rtl/core/fcw_fat_mem.sv
// fat byte store, one write port and one registered read port
module fcw_fat_mem #(
  parameter int unsigned Depth = fcw_pkg::FAT_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/fcw_checker.sv
// port-level checker for the fat12 cluster chain walker, bound to the top level
`include "fat12_cluster_chain_walker_top_assert.svh"

module fcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        action_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        is_read_o,
  input logic [15:0] sector_o,
  input logic [15:0] next_cluster_o,
  input logic        last_o
);

  // pending result is held until taken
  `FCW_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // a non-read result is the last of its walk and carries the end-of-file marker and sector zero
  `FCW_ASSERT_IMP(a_noread_eof, out_valid_o && !is_read_o,
                  last_o && next_cluster_o == fcw_pkg::END_OF_FILE && sector_o == 16'd0)

  // results before the last carry no resume cluster
  `FCW_ASSERT_IMP(a_mid_next_zero, out_valid_o && !last_o, next_cluster_o == 16'd0)

  // a walk transaction blocks the input side while it runs
  `FCW_ASSERT_NXT(a_walk_busy, in_valid_i && in_ready_o && action_i == fcw_pkg::ACT_WALK,
                  !in_ready_o)

endmodule

bind fat12_cluster_chain_walker_top fcw_checker u_fcw_checker (.*);
